// ----- design/ppcf_pkg.sv -----
// ----------------------------------------------------------------------------
// ppcf_pkg: shared types and constants for the parabolic peak charge fit
// Beat formats, the per-pulse record handed from front to back, and the
// request/response bundle of the shared divider.
// ----------------------------------------------------------------------------
package ppcf_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int IDX_W           = 6;
  localparam int CHARGE_W        = 14;
  localparam int TIME_W          = 26;
  localparam int PERIOD_W        = 16;
  localparam int MAX_SAMPLES_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;

  // Divider operand widths: 8*T*M needs 39 bits, 8*|A| needs 16 bits.
  localparam int DIV_DND_W = 39;
  localparam int DIV_DVS_W = 16;

  typedef enum logic [1:0] {
    CASE_NONE  = 2'd0,
    CASE_FIRST = 2'd1,
    CASE_LAST  = 2'd2,
    CASE_FIT   = 2'd3
  } peak_case_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [CHARGE_W-1:0] charge;
    logic [TIME_W-1:0]          fit_time;
    peak_case_e                 peak_case;
    logic [IDX_W-1:0]           peak_index;
    logic                       too_many;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y1;
    logic [SAMPLE_W-1:0] y2;
    logic [SAMPLE_W-1:0] y3;
    logic [SAMPLE_W-1:0] ped;
    logic [IDX_W-1:0]    idx;
    peak_case_e          pcase;
    logic                too_many;
  } rec_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DND_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/ppcf_front.sv -----
// ----------------------------------------------------------------------------
// ppcf_front: per-sample peak tracker
// Takes one sample per cycle unless full_o; keeps pedestal, first strict max,
// its neighbours, and on the last sample classifies the pulse into a record.
// ----------------------------------------------------------------------------
module ppcf_front #(
  parameter int MaxSamples = ppcf_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ppcf_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               full_o,
  output logic               rec_push_o,
  output ppcf_pkg::rec_t     rec_o
);

  localparam int CntW = $clog2(MaxSamples + 1);
  localparam int IdxW = ppcf_pkg::IDX_W;
  localparam int SW   = ppcf_pkg::SAMPLE_W;
  localparam int CmpW = CntW + IdxW;

  logic [CntW-1:0] count_q, count_d;
  logic [SW-1:0]   ped_q, ped_d, prev_q, prev_d, max_q, max_d;
  logic [SW-1:0]   before_q, before_d, after_q, after_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            pend_q, pend_d, ovf_q, ovf_d;
  logic            accept, keep;
  logic [SW-1:0]   s;
  logic [CntW-1:0] n_m1;

  assign full_o = q_full_i;
  assign accept = push_i & ~q_full_i;
  assign s      = in_data_i.sample;
  assign keep   = count_q < CntW'(MaxSamples);

  always_comb begin
    count_d  = count_q;
    ped_d    = ped_q;
    prev_d   = prev_q;
    max_d    = max_q;
    before_d = before_q;
    after_d  = after_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    ovf_d    = ovf_q;
    if (keep) begin
      if (count_q == '0) begin
        ped_d = s;
      end
      if (pend_q) begin
        after_d = s;
        pend_d  = 1'b0;
      end
      if (s > max_q) begin
        max_d    = s;
        pos_d    = IdxW'(count_q);
        before_d = prev_q;
        pend_d   = 1'b1;
      end
      prev_d  = s;
      count_d = count_q + CntW'(1);
    end else begin
      ovf_d = 1'b1;
    end
  end

  // Classify the pulse on the values after this beat.
  always_comb begin
    n_m1           = count_d - CntW'(1);
    rec_o.y1       = before_d;
    rec_o.y2       = max_d;
    rec_o.y3       = after_d;
    rec_o.ped      = ped_d;
    rec_o.idx      = '0;
    rec_o.pcase    = ppcf_pkg::CASE_NONE;
    rec_o.too_many = ovf_d;
    if (max_d != '0 && count_d != '0) begin
      rec_o.idx = pos_d;
      if (pos_d == '0) begin
        rec_o.pcase = ppcf_pkg::CASE_FIRST;
      end else if (CmpW'(pos_d) == CmpW'(n_m1)) begin
        rec_o.pcase = ppcf_pkg::CASE_LAST;
      end else begin
        rec_o.pcase = ppcf_pkg::CASE_FIT;
      end
    end
  end

  assign rec_push_o = accept & in_data_i.last_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ped_q    <= '0;
      prev_q   <= '0;
      max_q    <= '0;
      before_q <= '0;
      after_q  <= '0;
      pos_q    <= '0;
      pend_q   <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (accept) begin
      if (in_data_i.last_sample) begin
        // Start the next pulse clean.
        count_q  <= '0;
        ped_q    <= '0;
        prev_q   <= '0;
        max_q    <= '0;
        before_q <= '0;
        after_q  <= '0;
        pos_q    <= '0;
        pend_q   <= 1'b0;
        ovf_q    <= 1'b0;
      end else begin
        count_q  <= count_d;
        ped_q    <= ped_d;
        prev_q   <= prev_d;
        max_q    <= max_d;
        before_q <= before_d;
        after_q  <= after_d;
        pos_q    <= pos_d;
        pend_q   <= pend_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

// ----- design/ppcf_queue.sv -----
// ----------------------------------------------------------------------------
// ppcf_queue: short record queue between front and back
// Holds classified pulses so the tracker and the fit stall independently.
// ----------------------------------------------------------------------------
module ppcf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppcf_pkg::rec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ppcf_pkg::rec_t rec_o
);

  localparam int Depth = ppcf_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ppcf_pkg::rec_t  slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign rec_o   = slot_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- design/ppcf_div.sv -----
// ----------------------------------------------------------------------------
// ppcf_div: shared restoring divider
// Unsigned, one quotient bit per cycle; done pulses once the last bit lands.
// ----------------------------------------------------------------------------
module ppcf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppcf_pkg::div_req_t req_i,
  output ppcf_pkg::div_rsp_t rsp_o
);

  localparam int DndW = ppcf_pkg::DIV_DND_W;
  localparam int DvsW = ppcf_pkg::DIV_DVS_W;
  localparam int CntW = $clog2(DndW + 1);

  logic [DndW-1:0] quo_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DvsW:0]   rem_sh, rem_nx;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[DndW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DndW-2:0], ge};
      rem_q <= rem_nx[DvsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == CntW'(1));
      if (req_i.start) begin
        cnt_q  <= CntW'(DndW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/ppcf_back.sv -----
// ----------------------------------------------------------------------------
// ppcf_back: parabola fit sequencer and result register
// Pops a pulse record; if it is a fit, forms the fit terms over two multiply
// stages, runs charge and time divisions on the shared divider; holds result.
// ----------------------------------------------------------------------------
module ppcf_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rec_valid_i,
  input  ppcf_pkg::rec_t                  rec_i,
  output logic                            rec_pop_o,
  input  logic [ppcf_pkg::PERIOD_W-1:0]   period_i,
  output ppcf_pkg::div_req_t              div_req_o,
  input  ppcf_pkg::div_rsp_t              div_rsp_i,
  input  logic                            pop_i,
  output logic                            empty_o,
  output ppcf_pkg::out_item_t             out_data_o
);

  localparam int SW   = ppcf_pkg::SAMPLE_W;
  localparam int DndW = ppcf_pkg::DIV_DND_W;
  localparam int DvsW = ppcf_pkg::DIV_DVS_W;
  localparam int CW   = ppcf_pkg::CHARGE_W;
  localparam int TW   = ppcf_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIVC,
    S_DIVT,
    S_OUT
  } state_e;

  state_e              state_q;
  ppcf_pkg::rec_t      rec_q;
  ppcf_pkg::out_item_t res_q, out_q;
  logic                out_valid_q, start_q;

  // Fit terms: d = -A (always positive for a first strict maximum), b = B.
  logic [SW:0]           d_w;
  logic [SW:0]           d;
  logic signed [SW:0]    b, p;
  logic signed [25:0]    bb_full;
  logic [18:0]           dx;
  logic signed [20:0]    m_full;
  logic [SW:0]           d_q;
  logic signed [29:0]    pd_q;
  logic [24:0]           bb_q;
  logic [19:0]           m_q;
  logic signed [30:0]    n_q;
  logic [35:0]           tm_q;
  logic [30:0]           abs_n;
  logic [DndW-1:0]       qc;

  always_comb begin
    d_w     = {rec_q.y2, 1'b0} - {1'b0, rec_q.y1} - {1'b0, rec_q.y3};
    d       = d_w;
    b       = $signed({1'b0, rec_q.y3}) - $signed({1'b0, rec_q.y1});
    p       = $signed({1'b0, rec_q.y2}) - $signed({1'b0, rec_q.ped});
    bb_full = b * b;
    dx      = 19'(d) * 19'(rec_q.idx);
    m_full  = $signed({1'b0, dx, 1'b0}) + 21'(b);
    abs_n   = n_q[30] ? 31'(-n_q) : 31'(n_q);
    qc      = n_q[30] ? (~div_rsp_i.quotient + DndW'(1)) : div_rsp_i.quotient;
  end

  // Charge divides |N| by 8d, time divides 8*T*M by d.
  always_comb begin
    div_req_o.start = start_q;
    if (state_q == S_DIVT) begin
      div_req_o.dividend = {tm_q, 3'b000};
      div_req_o.divisor  = DvsW'(d_q);
    end else begin
      div_req_o.dividend = DndW'(abs_n);
      div_req_o.divisor  = DvsW'({d_q, 3'b000});
    end
  end

  assign rec_pop_o  = (state_q == S_IDLE) && rec_valid_i;
  assign empty_o    = ~out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL1) begin
      d_q  <= d;
      pd_q <= p * $signed({1'b0, d, 3'b000});
      bb_q <= bb_full[24:0];
      m_q  <= m_full[19:0];
    end
    if (state_q == S_MUL2) begin
      n_q  <= 31'(pd_q) + 31'($signed({1'b0, bb_q}));
      tm_q <= period_i * m_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rec_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
    end else begin
      start_q <= (state_q == S_MUL2) || (state_q == S_DIVC && div_rsp_i.done);
      if (pop_i && out_valid_q && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (rec_valid_i) begin
            rec_q              <= rec_i;
            res_q.peak_case    <= rec_i.pcase;
            res_q.peak_index   <= rec_i.idx;
            res_q.too_many     <= rec_i.too_many;
            res_q.fit_time     <= '0;
            if (rec_i.pcase == ppcf_pkg::CASE_NONE) begin
              res_q.charge <= '0;
            end else begin
              res_q.charge <= $signed(CW'(rec_i.y2));
            end
            state_q <= (rec_i.pcase == ppcf_pkg::CASE_FIT) ? S_MUL1 : S_OUT;
          end
        end
        S_MUL1: begin
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          state_q <= S_DIVC;
        end
        S_DIVC: begin
          if (div_rsp_i.done) begin
            res_q.charge <= $signed(qc[CW-1:0]);
            state_q      <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (div_rsp_i.done) begin
            res_q.fit_time <= div_rsp_i.quotient[TW-1:0];
            state_q        <= S_OUT;
          end
        end
        S_OUT: begin
          // Load when the result register is free or being drained this beat.
          if (!out_valid_q || pop_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/peak_parabolic_charge_fit.sv -----
// ----------------------------------------------------------------------------
// peak_parabolic_charge_fit: three-point parabolic peak fit per ADC pulse
// Samples go in through a queue-style port (push_i/full_o), one sample per
// beat, last_sample closing the pulse. One result per pulse comes out through
// empty_o/pop_i: charge less pedestal (fitted pulses; edge peaks give the
// raw sample), time in 1/16 ns, peak case, peak index and the overflow mark.
// Samples beyond MaxSamples are dropped. The sampling period is written on
// cfg_valid_i/cfg_ready_o/cfg_data_i; the user must write it only while no
// pulse is in flight, which the block does not enforce; ready is always high.
// Samples are taken one per cycle; full_o is high while the two-entry pulse
// queue is full, and then no sample is taken. From the closing beat a pulse
// without an interior peak passes the queue, the idle state and the output
// state before empty_o falls; a fitted pulse also passes S_MUL1, S_MUL2 and
// the shared one-bit-per-cycle divider, run twice (39 steps each, plus load
// and hand-over). The front keeps taking samples of later pulses while a fit
// runs, until the queue is full.
// Reset clears the pulse state, the queue and the result register and loads
// the period with 50 ns. While pop_i stays low the result holds, the fit
// waits, the queue fills and then full_o stalls the sender.
// ----------------------------------------------------------------------------
module peak_parabolic_charge_fit #(
  parameter int MaxSamples = ppcf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  ppcf_pkg::in_item_t            in_data_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output ppcf_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppcf_pkg::PERIOD_W-1:0] cfg_data_i
);

  logic [ppcf_pkg::PERIOD_W-1:0] period_q;
  logic                          q_full, q_push, q_valid, q_pop;
  ppcf_pkg::rec_t                q_wr_rec, q_rd_rec;
  ppcf_pkg::div_req_t            div_req;
  ppcf_pkg::div_rsp_t            div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= ppcf_pkg::PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= cfg_data_i;
    end
  end

  ppcf_front #(
    .MaxSamples(MaxSamples)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .full_o    (full_o),
    .rec_push_o(q_push),
    .rec_o     (q_wr_rec)
  );

  ppcf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .rec_i  (q_wr_rec),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rec_o  (q_rd_rec)
  );

  ppcf_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  ppcf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(q_valid),
    .rec_i      (q_rd_rec),
    .rec_pop_o  (q_pop),
    .period_i   (period_q),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_data_o (out_data_o)
  );

  // A closing beat never arrives at a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("pulse record pushed into a full queue");

  // A pulse without signal reports all-zero fit fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_data_o.peak_case == ppcf_pkg::CASE_NONE) |->
      (out_data_o.charge == '0 && out_data_o.fit_time == '0 &&
       out_data_o.peak_index == '0))
    else $error("no-signal result carries non-zero fields");

  // An edge peak reports the raw positive sample and no time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (out_data_o.peak_case == ppcf_pkg::CASE_FIRST ||
                  out_data_o.peak_case == ppcf_pkg::CASE_LAST)) |->
      (out_data_o.charge > 0 && out_data_o.fit_time == '0))
    else $error("edge-peak result malformed");

  // The divider is never started on consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_req.start)
    else $error("divider started on consecutive cycles");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for peak_parabolic_charge_fit
// Pushes ADC pulses one sample per beat, pops one result per pulse and
// compares every field against an in-bench model of the three-point peak fit.
// A short directed table comes first, then four random phases with a new
// sampling period each. Both sides idle at random outside the steady phase,
// and the popper stalls once for long enough to fill the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PhaseSamples = 400;
  localparam int DrainCycles  = 100;
  localparam int LongStall    = 400;

  typedef struct packed {
    logic [ppcf_pkg::SAMPLE_W-1:0] sample;
    logic                          last;
    logic                          typed;
    ppcf_pkg::out_item_t           want;
  } row_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          push_i      = 1'b0;
  logic                          full_o;
  ppcf_pkg::in_item_t            in_data_i   = '0;
  logic                          empty_o;
  logic                          pop_i       = 1'b0;
  ppcf_pkg::out_item_t           out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [ppcf_pkg::PERIOD_W-1:0] cfg_data_i  = '0;

  // model state, one pulse at a time
  logic [ppcf_pkg::PERIOD_W-1:0] period_ns = ppcf_pkg::PERIOD_RESET;
  logic [6:0]                    n_kept;
  logic [ppcf_pkg::SAMPLE_W-1:0] ped_y, prev_y, peak_y, before_y, after_y;
  logic [ppcf_pkg::IDX_W-1:0]    peak_at;
  logic                          after_due, dropped;

  ppcf_pkg::out_item_t pending_fits[$];
  row_t                plan[$];

  int  errors     = 0;
  int  n_samples  = 0;
  int  n_pulses   = 0;
  int  n_checked  = 0;
  int  n_fitted   = 0;
  int  n_overflow = 0;
  int  hold_left  = 0;
  bit  held       = 1'b0;
  bit  steady     = 1'b0;

  peak_parabolic_charge_fit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_data_i   (in_data_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_pulse();
    n_kept    = '0;
    ped_y     = '0;
    prev_y    = '0;
    peak_y    = '0;
    before_y  = '0;
    after_y   = '0;
    peak_at   = '0;
    after_due = 1'b0;
    dropped   = 1'b0;
  endfunction

  // Advance the pulse state by one sample; returns 1 with the result on the
  // closing sample.
  function automatic bit fit_pulse_step(input ppcf_pkg::in_item_t it,
                                        output ppcf_pkg::out_item_t r);
    longint y1, y2, y3, a, b, t, idx, chg, tv;
    r   = '0;
    chg = 0;
    tv  = 0;
    if (n_kept >= ppcf_pkg::MAX_SAMPLES_DEF) begin
      dropped = 1'b1;
    end else begin
      if (n_kept == 0) ped_y = it.sample;
      if (after_due) begin
        after_y   = it.sample;
        after_due = 1'b0;
      end
      if (it.sample > peak_y) begin
        peak_y    = it.sample;
        peak_at   = n_kept[ppcf_pkg::IDX_W-1:0];
        before_y  = prev_y;
        after_due = 1'b1;
      end
      prev_y = it.sample;
      n_kept = n_kept + 7'd1;
    end
    if (!it.last_sample) return 1'b0;

    r.peak_case = ppcf_pkg::CASE_NONE;
    if (peak_y != 0 && n_kept != 0) begin
      r.peak_index = peak_at;
      if (peak_at == 0) begin
        r.peak_case = ppcf_pkg::CASE_FIRST;
        chg = peak_y;
      end else if (peak_at == n_kept - 7'd1) begin
        r.peak_case = ppcf_pkg::CASE_LAST;
        chg = peak_y;
      end else begin
        r.peak_case = ppcf_pkg::CASE_FIT;
        y1  = before_y;
        y2  = peak_y;
        y3  = after_y;
        a   = y3 + y1 - 2 * y2;
        b   = y3 - y1;
        t   = period_ns;
        idx = peak_at;
        if (a == 0) begin
          chg = y2 - longint'(ped_y);
          tv  = 16 * t * idx;
        end else begin
          // both divisions truncate toward zero
          chg = ((y2 - longint'(ped_y)) * 8 * a - b * b) / (8 * a);
          tv  = (8 * t * (2 * a * idx - b)) / a;
        end
      end
    end
    r.charge   = chg[ppcf_pkg::CHARGE_W-1:0];
    r.fit_time = (tv < 0) ? '0 : tv[ppcf_pkg::TIME_W-1:0];
    r.too_many = dropped;
    clear_pulse();
    return 1'b1;
  endfunction

  function automatic ppcf_pkg::out_item_t res(input int chg, input int ftime,
                                              input ppcf_pkg::peak_case_e pc,
                                              input int idx, input bit ovf);
    ppcf_pkg::out_item_t r;
    r.charge     = chg[ppcf_pkg::CHARGE_W-1:0];
    r.fit_time   = ftime[ppcf_pkg::TIME_W-1:0];
    r.peak_case  = pc;
    r.peak_index = idx[ppcf_pkg::IDX_W-1:0];
    r.too_many   = ovf;
    return r;
  endfunction

  task automatic add_row(input int s, input bit last, input bit typed,
                         input ppcf_pkg::out_item_t want);
    row_t row;
    row  = '{s[ppcf_pkg::SAMPLE_W-1:0], last, typed, want};
    plan = {plan, row};
  endtask

  // Offer one sample beat; hold it until taken, then update the model.
  task automatic send_sample(input logic [ppcf_pkg::SAMPLE_W-1:0] s, input bit last,
                             input bit typed, input ppcf_pkg::out_item_t want);
    ppcf_pkg::in_item_t  it;
    ppcf_pkg::out_item_t r;
    it.sample      = s;
    it.last_sample = last;
    while (!steady && $urandom_range(0, 99) < 20) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (full_o);
    n_samples++;
    if (fit_pulse_step(it, r)) begin
      if (typed) r = want;
      pending_fits = {pending_fits, r};
      n_pulses++;
      if (r.peak_case == ppcf_pkg::CASE_FIT) n_fitted++;
      if (r.too_many) n_overflow++;
    end
  endtask

  task automatic send_random_pulse();
    int n, mode, p, base, top, v, k, pick;
    bit plateau;
    pick = $urandom_range(0, 99);
    if (pick < 6) n = 1;
    else if (pick < 16) n = $urandom_range(ppcf_pkg::MAX_SAMPLES_DEF + 1, 40);
    else n = $urandom_range(2, ppcf_pkg::MAX_SAMPLES_DEF);
    mode    = $urandom_range(0, 99);
    p       = $urandom_range(0, n - 1);
    base    = $urandom_range(0, 300);
    top     = $urandom_range(base, 4095);
    plateau = ($urandom_range(0, 4) == 0);
    for (k = 0; k < n; k++) begin
      if (mode < 8) begin
        v = 0;
      end else if (mode < 20) begin
        v = $urandom_range(0, 4095);
      end else if (mode < 32) begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 4095;
          2: v = $urandom_range(0, 4095);
          default: v = 1 << $urandom_range(0, 11);
        endcase
      end else begin
        // rise to the peak, fall away, with a little noise on top
        if (k < p) v = base + (top - base) * (k + 1) / (p + 1);
        else if (k == p || (plateau && k == p + 1)) v = top;
        else v = top - (top - base) * (k - p) / (n - p);
        v = v + $urandom_range(0, 7);
        if (v > 4095) v = 4095;
      end
      send_sample(v[ppcf_pkg::SAMPLE_W-1:0], k == n - 1, 1'b0, '0);
    end
  endtask

  // Drain, retune the period, then run a batch of random pulses.
  task automatic run_phase(input logic [ppcf_pkg::PERIOD_W-1:0] period, input bit no_idle);
    int start;
    push_i <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= period;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period_ns = period;
    steady    = no_idle;
    start     = n_samples;
    while (n_samples - start < PhaseSamples) send_random_pulse();
  endtask

  task automatic check_result(input ppcf_pkg::out_item_t got);
    ppcf_pkg::out_item_t want;
    if (pending_fits.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, charge %0d time %0d case %0d", $time,
               got.charge, got.fit_time, got.peak_case);
      return;
    end
    want = pending_fits.pop_front();
    n_checked++;
    if (got.charge !== want.charge) begin
      errors++;
      $display("%0t: charge expected %0d, got %0d", $time, want.charge, got.charge);
    end
    if (got.fit_time !== want.fit_time) begin
      errors++;
      $display("%0t: fit_time expected %0d, got %0d", $time, want.fit_time, got.fit_time);
    end
    if (got.peak_case !== want.peak_case) begin
      errors++;
      $display("%0t: peak_case expected %0d, got %0d", $time, want.peak_case, got.peak_case);
    end
    if (got.peak_index !== want.peak_index) begin
      errors++;
      $display("%0t: peak_index expected %0d, got %0d", $time, want.peak_index,
               got.peak_index);
    end
    if (got.too_many !== want.too_many) begin
      errors++;
      $display("%0t: too_many expected %0d, got %0d", $time, want.too_many, got.too_many);
    end
  endtask

  // Result side: take a beat, then pick pop for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) check_result(out_data_o);
    if (hold_left > 0) begin
      hold_left--;
      pop_i <= 1'b0;
    end else if (!held && n_checked >= 20) begin
      // stall long enough for the pulse queue to fill and block the sender
      held      = 1'b1;
      hold_left = LongStall - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    int k;
    clear_pulse();

    add_row(0, 1'b1, 1'b1, res(0, 0, ppcf_pkg::CASE_NONE, 0, 1'b0));
    add_row(4095, 1'b1, 1'b1, res(4095, 0, ppcf_pkg::CASE_FIRST, 0, 1'b0));
    add_row(0, 1'b0, 1'b0, '0);
    add_row(4095, 1'b1, 1'b1, res(4095, 0, ppcf_pkg::CASE_LAST, 1, 1'b0));
    add_row(10, 1'b0, 1'b0, '0);
    add_row(20, 1'b0, 1'b0, '0);
    add_row(4095, 1'b0, 1'b0, '0);
    add_row(0, 1'b1, 1'b0, '0);
    // overlong pulse with a plateau after the peak; the closing 4095 is dropped
    for (k = 0; k < ppcf_pkg::MAX_SAMPLES_DEF; k++) begin
      if (k <= 7) add_row(5 + k * 570, 1'b0, 1'b0, '0);
      else if (k == 8) add_row(3995, 1'b0, 1'b0, '0);
      else add_row(3995 - (k - 8) * 400, 1'b0, 1'b0, '0);
    end
    add_row(4095, 1'b1, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_sample(plan[i].sample, plan[i].last, plan[i].typed, plan[i].want);

    run_phase(16'hFFFF, 1'b0);
    run_phase(16'd0, 1'b1);
    run_phase(16'($urandom_range(2, 65534)), 1'b0);
    run_phase(16'd1, 1'b0);

    push_i <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d samples in %0d pulses over five sampling periods, %0d results checked",
             n_samples, n_pulses, n_checked);
    $display("Fitted peaks: %0d, overlong pulses: %0d, one %0d-cycle result stall",
             n_fitted, n_overflow, LongStall);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
